### rtl/core/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and constants shared by the Go-Back-N send window modules.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam logic [1:0] OP_ACK   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [2:0] K_TX      = 3'd0;
  localparam logic [2:0] K_ACK_OK  = 3'd1;
  localparam logic [2:0] K_ACK_DUP = 3'd2;
  localparam logic [2:0] K_ACK_OOR = 3'd3;
  localparam logic [2:0] K_REFUSED = 3'd4;
  localparam logic [2:0] K_IDLE    = 3'd5;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_SENT  = 2'd1;
  localparam logic [1:0] ST_ACKED = 2'd2;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_START   = 2'd1;
  localparam logic [1:0] REG_WINDOW  = 2'd2;

  localparam int unsigned MAX_RES = 8;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] ack_seq;
    logic [11:0] payload_len;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] seq;
    logic [2:0]  slot;
    logic [11:0] pkt_bytes;
    logic        retransmit;
    logic [15:0] window_base;
    logic [15:0] window_next;
    logic [31:0] bytes_total;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_ACK, S_ADV, S_TMO_CHK, S_RESEND, S_OUT
  } fsm_e;

endpackage

### rtl/core/gbn_if.sv
// ----------------------------------------------------------------------------
// gbn_if
// Valid/ready channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface gbn_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/go_back_n_send_window.sv
// ----------------------------------------------------------------------------
// go_back_n_send_window
// Go-Back-N sender window: slot table in memory, walked by a sequencer.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_if (ack, tick, load); each request yields one
// or more result items on out_if, the final one flagged by last. Config
// writes (timeout, start sequence, window size) go through cfg_we_i while
// the block is idle.
// Slot length and time live in one memory of WINDOW entries, read through a
// register. A request is handled one at a time: load, bad ack, empty-window
// tick and unused opcode give a single result; an ok ack walks the slots
// from the base up to the ack; an advance frees the acked slots at the base;
// a tick on an unacked base reads the base entry and checks its timeout; a
// resend sends the outstanding packets, up to MAX_RES. Each slot walked by an
// ack or a resend is read with an address phase, then a data phase.
// Results sit in an output register; a stalled receiver holds the sequencer
// and the next request waits. Reset empties the window: slot states are
// per-slot flops cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module go_back_n_send_window #(
  parameter int unsigned WINDOW      = 8,
  parameter int unsigned MAX_PAYLOAD = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  gbn_if.sink         in_if,
  gbn_if.source       out_if
);
  import gbn_pkg::*;

  localparam int unsigned SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned WEFF = (WINDOW < MAX_RES) ? WINDOW : MAX_RES;

  // memory entry: length and send time; state bits kept in flops (reset)
  logic [43:0] mem [WINDOW];
  logic [43:0] rd_q;
  logic [1:0]  st_q [WINDOW];

  logic [31:0] tmo_q;
  logic [3:0]  win_q;
  logic [15:0] base_q, next_q;
  logic [SW-1:0] bslot_q;
  logic [31:0] tot_q;

  fsm_e        fsm_q, fsm_d;
  in_item_t    it_q;
  logic [15:0] cnt_q;          // walk index
  logic [15:0] lim_q;          // walk end
  logic        ph_q;           // walk read phase: 0 address, 1 data
  out_item_t   o_q;
  logic        ov_q;

  logic [15:0] n;
  logic [15:0] d;
  logic [3:0]  weff;
  logic [SW-1:0] cur_slot;
  logic [SW-1:0] load_slot;
  logic        load_ok;
  logic        adv_more;
  logic [31:0] tmo_eff;
  logic        timed_out;
  logic        rs_last;
  logic [31:0] ack_add;

  assign n = next_q - base_q;
  assign d = it_q.ack_seq - base_q;
  always_comb begin
    weff = win_q;
    if (weff == 4'd0) weff = 4'd1;
    if (32'(weff) > WEFF) weff = 4'(WEFF);
  end

  function automatic logic [SW-1:0] slot_add(logic [SW-1:0] b, logic [15:0] off);
    logic [SW:0] s;
    s = {1'b0, b} + {1'b0, off[SW-1:0]};
    if (s >= (SW+1)'(WINDOW)) s = s - (SW+1)'(WINDOW);
    return s[SW-1:0];
  endfunction

  // offsets stay below WINDOW, so one conditional subtract wraps
  assign cur_slot  = slot_add(bslot_q, cnt_q);
  assign load_slot = slot_add(bslot_q, n);
  assign load_ok   = n < 16'(weff);
  assign adv_more  = (base_q != next_q) && (st_q[bslot_q] == ST_ACKED);
  assign tmo_eff   = (tmo_q == 32'd0) ? 32'd1 : tmo_q;
  assign timed_out = (it_q.now_time - rd_q[31:0]) >= tmo_eff;
  assign rs_last   = (cnt_q + 16'd1 == n) || (cnt_q + 16'd1 == 16'(MAX_RES));
  assign ack_add   = (st_q[cur_slot] == ST_SENT) ? 32'(rd_q[43:32]) : 32'd0;

  assign in_if.ready  = (fsm_q == S_IDLE);
  assign out_if.valid = ov_q;
  assign out_if.data  = o_q;

  logic [11:0] plen_sat;
  always_comb begin
    plen_sat = it_q.payload_len;
    if (32'(plen_sat) > MAX_PAYLOAD) plen_sat = 12'(MAX_PAYLOAD);
  end

  function automatic out_item_t mk(logic [2:0] k, logic [15:0] b, logic [15:0] nx,
                                   logic [31:0] t, logic l);
    out_item_t r;
    r = '0;
    r.kind = k; r.window_base = b; r.window_next = nx; r.bytes_total = t; r.last = l;
    return r;
  endfunction

  function automatic out_item_t mk_tx(logic [15:0] s, logic [SW-1:0] sl,
                                      logic [11:0] bytes, logic re, logic [15:0] b,
                                      logic [15:0] nx, logic [31:0] t, logic l);
    out_item_t r;
    r = mk(K_TX, b, nx, t, l);
    r.seq = s; r.slot = 3'(sl); r.pkt_bytes = bytes; r.retransmit = re;
    return r;
  endfunction

  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      S_IDLE: if (in_if.valid) fsm_d = S_RD;
      S_RD: begin
        if (!ov_q) begin
          case (it_q.opcode)
            OP_ACK:  fsm_d = (d < n) ? S_ACK : S_IDLE;
            OP_TICK: begin
              if (n == 16'd0) fsm_d = S_IDLE;
              else if (st_q[bslot_q] == ST_ACKED) fsm_d = S_ADV;
              else fsm_d = S_TMO_CHK;   // rd_q holds base entry next cycle
            end
            default: fsm_d = S_IDLE;
          endcase
        end
      end
      S_ACK:     if (ph_q && cnt_q == lim_q) fsm_d = S_OUT;
      S_ADV:     if (!adv_more) fsm_d = S_OUT;
      S_TMO_CHK: if (ph_q) fsm_d = timed_out ? S_RESEND : S_OUT;
      S_RESEND:  if (!ov_q && ph_q && rs_last) fsm_d = S_OUT;
      default:   fsm_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fsm_q <= S_IDLE;
    else fsm_q <= fsm_d;
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[cur_slot];
    if (fsm_q == S_RD && it_q.opcode == OP_LOAD && load_ok && !ov_q)
      mem[load_slot] <= {plen_sat, it_q.now_time};
    else if (fsm_q == S_RESEND && ph_q && !ov_q)
      mem[cur_slot] <= {rd_q[43:32], it_q.now_time};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= 32'd1000; win_q <= 4'd8;
      base_q <= '0; next_q <= '0; bslot_q <= '0; tot_q <= '0;
      ov_q <= 1'b0; cnt_q <= '0; lim_q <= '0; ph_q <= 1'b0;
      it_q <= '0; o_q <= '0;
      for (int i = 0; i < WINDOW; i++) st_q[i] <= ST_EMPTY;
    end else begin
      if (ov_q && out_if.ready) ov_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TIMEOUT: tmo_q <= cfg_data_i;
          REG_START: begin
            // start sequence only moves an empty window
            if (base_q == next_q) begin
              base_q <= cfg_data_i[15:0]; next_q <= cfg_data_i[15:0];
            end
          end
          REG_WINDOW: win_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      case (fsm_q)
        S_IDLE: if (in_if.valid) begin
          it_q <= in_if.data; cnt_q <= '0; ph_q <= 1'b0;
        end
        S_RD: if (!ov_q) begin
          case (it_q.opcode)
            OP_LOAD: begin
              if (load_ok) begin
                st_q[load_slot] <= ST_SENT;
                next_q <= next_q + 16'd1;
                o_q <= mk_tx(next_q, load_slot, plen_sat, 1'b0, base_q,
                             next_q + 16'd1, tot_q, 1'b1);
              end else o_q <= mk(K_REFUSED, base_q, next_q, tot_q, 1'b1);
              ov_q <= 1'b1;
            end
            OP_ACK: begin
              if (d < n) begin
                lim_q <= d;
              end else begin
                o_q <= mk(d[15] ? K_ACK_DUP : K_ACK_OOR, base_q, next_q, tot_q, 1'b1);
                ov_q <= 1'b1;
              end
            end
            OP_TICK: begin
              if (n == 16'd0) begin
                o_q <= mk(K_IDLE, base_q, next_q, tot_q, 1'b1);
                ov_q <= 1'b1;
              end
            end
            default: begin
              o_q <= mk(K_IDLE, base_q, next_q, tot_q, 1'b1);
              ov_q <= 1'b1;
            end
          endcase
        end
        S_ACK: begin
          // ph 0: address cur_slot issued; ph 1: rd_q valid
          if (!ph_q) ph_q <= 1'b1;
          else begin
            ph_q <= 1'b0;
            if (st_q[cur_slot] == ST_SENT) st_q[cur_slot] <= ST_ACKED;
            tot_q <= tot_q + ack_add;
            if (cnt_q == lim_q) begin
              o_q <= mk(K_ACK_OK, base_q, next_q, tot_q + ack_add, 1'b1);
              ov_q <= 1'b1;
            end else cnt_q <= cnt_q + 16'd1;
          end
        end
        S_ADV: begin
          if (adv_more) begin
            st_q[bslot_q] <= ST_EMPTY;
            base_q <= base_q + 16'd1;
            bslot_q <= slot_add(bslot_q, 16'd1);
          end else begin
            o_q <= mk(K_IDLE, base_q, next_q, tot_q, 1'b1);
            ov_q <= 1'b1;
          end
        end
        S_TMO_CHK: begin
          if (!ph_q) ph_q <= 1'b1;
          else begin
            ph_q <= 1'b0;
            if (!timed_out) begin
              o_q <= mk(K_IDLE, base_q, next_q, tot_q, 1'b1);
              ov_q <= 1'b1;
            end
          end
        end
        S_RESEND: begin
          // wait on a stalled output; ph_q as read phase
          if (!ov_q) begin
            if (!ph_q) ph_q <= 1'b1;
            else begin
              ph_q <= 1'b0;
              st_q[cur_slot] <= ST_SENT;
              o_q <= mk_tx(base_q + cnt_q, cur_slot, rd_q[43:32], 1'b1, base_q,
                           next_q, tot_q, rs_last);
              ov_q <= 1'b1;
              if (!rs_last) cnt_q <= cnt_q + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Regression for go_back_n_send_window: directed and random ack, tick and
// load requests against a behavioral window predictor, with random idling on
// both channels and config changes between phases.
// ----------------------------------------------------------------------------
module testbench;
  import gbn_pkg::*;

  localparam int unsigned WIN = 8;
  localparam int unsigned MAXP = 4095;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  gbn_if #(.T(in_item_t))  in_if ();
  gbn_if #(.T(out_item_t)) out_if ();

  go_back_n_send_window #(.WINDOW(WIN), .MAX_PAYLOAD(MAXP)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---- predictor state: a shadow copy of the send window ----
  logic [31:0] win_timeout;
  logic [15:0] win_start;
  logic [3:0]  win_size;
  logic [15:0] base_sq;
  logic [15:0] next_sq;
  logic [1:0]  slot_st [WIN];
  logic [11:0] slot_ln [WIN];
  logic [31:0] slot_tm [WIN];
  logic [31:0] acked_bytes;
  int unsigned base_sl;

  out_item_t   results_due [$];
  in_item_t    requests_pending [$];
  int unsigned failures;
  bit          sender_hold;    // pause sender until drain
  bit          quiet;          // no idling in final stretch
  logic        hold_off;       // long receiver hold-off in progress
  event        hold_go;

  function automatic int unsigned window_limit();
    int unsigned w;
    w = win_size;
    if (w == 0) w = 1;
    if (w > WIN) w = WIN;
    if (w > MAX_RES) w = MAX_RES;
    return w;
  endfunction

  function automatic int unsigned slot_for(logic [15:0] s);
    logic [15:0] off;
    off = s - base_sq;
    return (base_sl + off % WIN) % WIN;
  endfunction

  function automatic void push_result(logic [2:0] k, logic [15:0] s, int unsigned sl,
                                      logic [11:0] b, logic re);
    out_item_t r;
    r.kind = k;
    r.seq = s;
    r.slot = sl[2:0];
    r.pkt_bytes = b;
    r.retransmit = re;
    r.window_base = base_sq;
    r.window_next = next_sq;
    r.bytes_total = acked_bytes;
    r.last = 1'b0;
    results_due.push_back(r);
  endfunction

  // Works out the results of one accepted request and updates the shadow.
  function automatic void predict_window(in_item_t q);
    int unsigned n, s, d, bs, tmo, cnt;
    logic [15:0] sq;
    n = 16'(next_sq - base_sq);
    cnt = results_due.size();
    if (q.opcode == OP_LOAD) begin
      if (n < window_limit()) begin
        s = slot_for(next_sq);
        sq = next_sq;
        slot_st[s] = ST_SENT;
        slot_ln[s] = q.payload_len;
        slot_tm[s] = q.now_time;
        next_sq = next_sq + 16'd1;
        push_result(K_TX, sq, s, slot_ln[s], 1'b0);
      end else begin
        push_result(K_REFUSED, 16'd0, 0, 12'd0, 1'b0);
      end
    end else if (q.opcode == OP_ACK) begin
      d = 16'(q.ack_seq - base_sq);
      if (d < n) begin
        for (int unsigned i = 0; i <= d; i++) begin
          s = slot_for(base_sq + 16'(i));
          if (slot_st[s] == ST_SENT) begin
            slot_st[s] = ST_ACKED;
            acked_bytes = acked_bytes + slot_ln[s];
          end
        end
        push_result(K_ACK_OK, 16'd0, 0, 12'd0, 1'b0);
      end else if (d >= 32768) begin
        push_result(K_ACK_DUP, 16'd0, 0, 12'd0, 1'b0);
      end else begin
        push_result(K_ACK_OOR, 16'd0, 0, 12'd0, 1'b0);
      end
    end else if (q.opcode == OP_TICK && n > 0) begin
      bs = base_sl % WIN;
      tmo = (win_timeout == 0) ? 1 : win_timeout;
      if (slot_st[bs] == ST_ACKED) begin
        // slide past every acked packet at the base
        while (base_sq != next_sq && slot_st[base_sl % WIN] == ST_ACKED) begin
          slot_st[base_sl % WIN] = ST_EMPTY;
          base_sq = base_sq + 16'd1;
          base_sl = (base_sl + 1) % WIN;
        end
        push_result(K_IDLE, 16'd0, 0, 12'd0, 1'b0);
      end else if (32'(q.now_time - slot_tm[bs]) >= tmo) begin
        for (int unsigned i = 0; i < n && i < MAX_RES; i++) begin
          sq = base_sq + 16'(i);
          s = slot_for(sq);
          slot_st[s] = ST_SENT;
          slot_tm[s] = q.now_time;
          push_result(K_TX, sq, s, slot_ln[s], 1'b1);
        end
      end else begin
        push_result(K_IDLE, 16'd0, 0, 12'd0, 1'b0);
      end
    end else begin
      // empty-window tick and unused opcode: one idle result
      push_result(K_IDLE, 16'd0, 0, 12'd0, 1'b0);
    end
    if (results_due.size() > cnt) results_due[results_due.size() - 1].last = 1'b1;
  endfunction

  function automatic void shadow_reset();
    win_timeout = 32'd1000;
    win_start = 16'd0;
    win_size = 4'd8;
    base_sq = 16'd0;
    next_sq = 16'd0;
    acked_bytes = 32'd0;
    base_sl = 0;
    for (int i = 0; i < WIN; i++) begin
      slot_st[i] = ST_EMPTY;
      slot_ln[i] = 12'd0;
      slot_tm[i] = 32'd0;
    end
  endfunction

  // ---- driver: offers requests from the pending queue ----
  int unsigned src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
      src_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) predict_window(in_if.data);
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) src_gap--;
        if (!quiet && src_gap == 0 && $urandom_range(0, 9) == 0)
          src_gap = $urandom_range(1, 17);
        if (src_gap == 0 && !sender_hold && requests_pending.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.data <= requests_pending.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---- long receiver hold-off, counted in cycles ----
  initial begin
    hold_off = 1'b0;
    forever begin
      @(hold_go);
      hold_off <= 1'b1;
      repeat (400) @(posedge clk_i);
      hold_off <= 1'b0;
    end
  end

  // ---- receiver: random stalls plus the long hold-off ----
  int unsigned sink_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (sink_gap > 0) sink_gap--;
      if (!quiet && sink_gap == 0 && $urandom_range(0, 9) == 0)
        sink_gap = $urandom_range(1, 17);
      out_if.ready <= (sink_gap == 0 && !hold_off);
    end
  end

  // ---- monitor: compares each accepted result with the oldest expected ----
  always @(posedge clk_i) begin
    out_item_t want, got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (results_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $time, got);
        failures++;
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind ||
            got.seq !== want.seq ||
            got.slot !== want.slot ||
            got.pkt_bytes !== want.pkt_bytes ||
            got.retransmit !== want.retransmit ||
            got.window_base !== want.window_base ||
            got.window_next !== want.window_next ||
            got.bytes_total !== want.bytes_total ||
            got.last !== want.last) begin
          $display("%0t result mismatch: expected %p, actual %p", $time, want, got);
          failures++;
        end
      end
    end
  end

  function automatic in_item_t make_req(logic [1:0] op, logic [15:0] a,
                                        logic [11:0] len, logic [31:0] t);
    in_item_t q;
    q.opcode = op;
    q.ack_seq = a;
    q.payload_len = len;
    q.now_time = t;
    return q;
  endfunction

  // Waits until the sender is empty and every expected result has come,
  // then lets the slowest request path finish before touching config.
  task automatic drain();
    while (requests_pending.size() > 0 || in_if.valid || results_due.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TIMEOUT) win_timeout = val;
    else if (idx == REG_START) begin
      win_start = val[15:0];
      if (base_sq == next_sq) begin
        base_sq = win_start;
        next_sq = win_start;
      end
    end else if (idx == REG_WINDOW) win_size = val[3:0];
  endtask

  // One random phase: mostly well-formed load/ack/tick traffic.
  // Times run forward from a clock base so timeouts fire now and then.
  logic [31:0] sim_now;
  task automatic random_phase(int unsigned cnt, int unsigned tmo_span);
    int unsigned r;
    logic [15:0] a;
    for (int unsigned i = 0; i < cnt; i++) begin
      r = $urandom_range(0, 99);
      sim_now = sim_now + $urandom_range(0, tmo_span);
      if (r < 40) begin
        requests_pending.push_back(make_req(OP_LOAD, 16'($urandom),
                                            12'($urandom), sim_now));
      end else if (r < 65) begin
        // ack near the current window, sometimes far off
        a = next_sq + 16'($urandom_range(0, 12)) - 16'd9;
        if ($urandom_range(0, 7) == 0) a = 16'($urandom);
        requests_pending.push_back(make_req(OP_ACK, a, 12'($urandom), sim_now));
      end else if (r < 97) begin
        requests_pending.push_back(make_req(OP_TICK, 16'($urandom),
                                            12'($urandom), sim_now));
      end else begin
        requests_pending.push_back(make_req(OP_SPARE, 16'($urandom),
                                            12'($urandom), $urandom));
      end
    end
  endtask

  initial begin
    failures = 0;
    sender_hold = 1'b0;
    quiet = 1'b0;
    sim_now = 32'd0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TIMEOUT;
    cfg_data_i = 32'd0;
    shadow_reset();
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-window acks and tick, loads at length extremes, fill,
    // refusal, ack classes, advance, timeout resend, unused opcode.
    requests_pending.push_back(make_req(OP_TICK, 16'h0, 12'h0, 32'h0));
    requests_pending.push_back(make_req(OP_ACK, 16'h0, 12'h0, 32'h0));
    requests_pending.push_back(make_req(OP_ACK, 16'hFFFF, 12'hFFF, 32'hFFFFFFFF));
    for (int i = 0; i < 8; i++)
      requests_pending.push_back(make_req(OP_LOAD, 16'hFFFF,
                                          (i == 0) ? 12'h000 : 12'hFFF - 12'(i), 32'd10));
    requests_pending.push_back(make_req(OP_LOAD, 16'h0, 12'hABC, 32'd11));
    requests_pending.push_back(make_req(OP_ACK, 16'd8, 12'h0, 32'd12));
    requests_pending.push_back(make_req(OP_ACK, 16'hFFF0, 12'h0, 32'd12));
    requests_pending.push_back(make_req(OP_ACK, 16'd2, 12'h0, 32'd12));
    requests_pending.push_back(make_req(OP_ACK, 16'd1, 12'h0, 32'd12));
    requests_pending.push_back(make_req(OP_TICK, 16'h0, 12'h0, 32'd13));
    requests_pending.push_back(make_req(OP_TICK, 16'h0, 12'h0, 32'd500));
    requests_pending.push_back(make_req(OP_TICK, 16'h0, 12'h0, 32'd1010));
    requests_pending.push_back(make_req(OP_SPARE, 16'hFFFF, 12'hFFF, 32'hFFFFFFFF));
    requests_pending.push_back(make_req(OP_ACK, 16'd7, 12'h0, 32'd1011));
    requests_pending.push_back(make_req(OP_TICK, 16'h0, 12'h0, 32'd1012));
    drain();

    // Small timeout, start near the wrap, tiny window.
    sim_now = 32'hFFFF_FF00;  // time stamps start just below the wrap
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_START, 32'h0000_FFFA);
    write_reg(REG_WINDOW, 32'd1);
    random_phase(40, 3);
    drain();

    // Long receiver hold-off: block fills and stalls its input.
    write_reg(REG_WINDOW, 32'd0);
    write_reg(REG_TIMEOUT, 32'd5);
    -> hold_go;
    random_phase(50, 4);
    drain();

    // Sender pauses until every result is in, then resumes.
    write_reg(REG_WINDOW, 32'd15);
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    random_phase(30, 10);
    repeat (60) @(posedge clk_i);
    sender_hold = 1'b1;
    while (in_if.valid || results_due.size() > 0) @(posedge clk_i);
    sender_hold = 1'b0;
    drain();
    write_reg(REG_TIMEOUT, 32'd20);
    write_reg(REG_WINDOW, 32'd3);
    write_reg(REG_START, 32'd1234);  // only moves base if window is empty
    random_phase(50, 8);
    drain();

    // Shrink window below outstanding count, then final stretch without idling.
    write_reg(REG_WINDOW, 32'd8);
    write_reg(REG_TIMEOUT, 32'd12);
    random_phase(40, 6);
    drain();
    write_reg(REG_WINDOW, 32'd2);
    quiet = 1'b1;
    random_phase(40, 6);
    drain();

    if (failures == 0) begin
      $display("go_back_n_send_window regression: pass");
    end else begin
      $display("go_back_n_send_window regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("go_back_n_send_window regression: fail");
    $finish;
  end

endmodule

### files.f
rtl/core/gbn_pkg.sv
rtl/core/gbn_if.sv
rtl/core/go_back_n_send_window.sv
bench/testbench.sv
